/* design/keyed_record_table_core_defines.svh */
// assertion macros for the keyed record table
`ifndef KEYED_RECORD_TABLE_CORE_DEFINES_SVH
`define KEYED_RECORD_TABLE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define KRT_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define KRT_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

/* design/krt_pkg.sv */
// shared types and constants of the keyed record table
package krt_pkg;

  localparam int KEY_W  = 32;
  localparam int YEAR_W = 16;

  // cells per first-match group
  localparam int GROUP_SIZE = 16;
  localparam int LOCAL_W    = $clog2(GROUP_SIZE);

  // request codes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // per-cell control from the sequencer
  typedef struct packed {
    logic cmp;    // register the key compare
    logic live;   // cell lies below the record count
    logic load;   // write the request record
    logic shift;  // take the upper neighbor's record
  } cell_ctl_t;

endpackage

/* design/krt_cell.sv */
// one table slot: record storage, key compare and shift from the upper neighbor
module krt_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  krt_pkg::cell_ctl_t            ctl,
  input  logic [krt_pkg::KEY_W-1:0]     req_key,
  input  logic [krt_pkg::YEAR_W-1:0]    req_year,
  input  logic [krt_pkg::KEY_W-1:0]     nbr_key,
  input  logic [krt_pkg::YEAR_W-1:0]    nbr_year,
  output logic [krt_pkg::KEY_W-1:0]     key,
  output logic [krt_pkg::YEAR_W-1:0]    year,
  output logic                          hit
);

  // record storage
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key  <= req_key;
      year <= req_year;
    end else if (ctl.shift) begin
      key  <= nbr_key;
      year <= nbr_year;
    end
  end

  // registered match flag
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctl.cmp) begin
      hit <= ctl.live && (key == req_key);
    end
  end

endmodule

/* design/krt_first_pick.sv */
// registered lowest-index pick over a row of match flags with attached data
module krt_first_pick #(
  parameter  int N   = 16,
  parameter  int DW  = 16,
  localparam int IXW = (N > 1) ? $clog2(N) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic [N-1:0]         hit,
  input  logic [N-1:0][DW-1:0] data,
  output logic                 any,
  output logic [IXW-1:0]       idx,
  output logic [DW-1:0]        dout
);

  logic           pick_any;
  logic [IXW-1:0] pick_idx;
  logic [DW-1:0]  pick_data;

  // priority encode, lowest index wins
  always_comb begin
    pick_any  = 1'b0;
    pick_idx  = '0;
    pick_data = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (hit[i]) begin
        pick_any  = 1'b1;
        pick_idx  = IXW'(i);
        pick_data = data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      any <= 1'b0;
    end else if (en) begin
      any <= pick_any;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx  <= pick_idx;
      dout <= pick_data;
    end
  end

endmodule

/* design/keyed_record_table_core.sv */
// Packed record table of CAPACITY slots, each a 32-bit key with a 16-bit year, held in a
// chain of cells. A request runs from accept to result beat through key compare in
// every cell, first match within groups of 16 cells, first match across groups, then
// execute (append, report or shift every later cell down one slot in a single step).
// While a request is running, the next one is accepted only in its execute cycle;
// execute waits while the previous result beat is not taken.
// Add to a full table reports full, search or delete of an empty table reports empty,
// an absent key reports not found and leaves the table unchanged.
module keyed_record_table_core #(
  parameter int CAPACITY = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // req_type[1:0], rec_key[33:2], rec_year[49:34], zeros
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata   // status[1:0], position[9:2], found_year[25:10],
                                // entry_total[33:26], zeros
);

`include "keyed_record_table_core_defines.svh"

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int IW  = $clog2(CAPACITY);
  localparam int GS  = krt_pkg::GROUP_SIZE;
  localparam int LW  = krt_pkg::LOCAL_W;
  localparam int NG  = (CAPACITY + GS - 1) / GS;
  localparam int GIW = (NG > 1) ? $clog2(NG) : 1;
  localparam int KW  = krt_pkg::KEY_W;
  localparam int YW  = krt_pkg::YEAR_W;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CMP   = 3'd1;
  localparam logic [2:0] S_PICKA = 3'd2;
  localparam logic [2:0] S_PICKB = 3'd3;
  localparam logic [2:0] S_EXEC  = 3'd4;

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [1:0]    req_op;
  logic [KW-1:0] req_key;
  logic [YW-1:0] req_year;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          exec_go;
  logic          in_beat;

  logic [CAPACITY-1:0][KW-1:0] cell_key;
  logic [CAPACITY-1:0][YW-1:0] cell_year;
  logic [CAPACITY-1:0]         cell_hit;
  logic [CAPACITY-1:0]         cell_load;
  logic [NG*GS-1:0]            hit_pad;
  logic [NG*GS-1:0][YW-1:0]    year_pad;

  logic [NG-1:0]              grp_any;
  logic [NG-1:0][LW+YW-1:0]   grp_data;
  logic                       found;
  logic [GIW-1:0]             grp_sel;
  logic [LW+YW-1:0]           pick_data;
  logic [IW-1:0]              slot;
  logic [YW-1:0]              slot_year;
  logic                       full;
  logic                       empty;

  logic [1:0]    res_status;
  logic [CW-1:0] res_pos;
  logic [YW-1:0] res_year;

  // handshake
  assign exec_go  = (state == S_EXEC) && (!m_tvalid || m_tready);
  assign s_tready = (state == S_IDLE) || exec_go;
  assign in_beat  = s_tvalid && s_tready;

  // request capture
  always_ff @(posedge clk) begin
    if (in_beat) begin
      req_op   <= s_tdata[1:0];
      req_key  <= s_tdata[33:2];
      req_year <= s_tdata[49:34];
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_beat) state_next = S_CMP;
      S_CMP:   state_next = S_PICKA;
      S_PICKA: state_next = S_PICKB;
      S_PICKB: state_next = S_EXEC;
      S_EXEC: begin
        if (exec_go) state_next = in_beat ? S_CMP : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign full  = (count == CW'(CAPACITY));
  assign empty = (count == '0);

  // chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    krt_pkg::cell_ctl_t      ctl;
    logic [KW-1:0]           nbr_key;
    logic [YW-1:0]           nbr_year;

    if (i + 1 < CAPACITY) begin : g_nbr
      assign nbr_key  = cell_key[i+1];
      assign nbr_year = cell_year[i+1];
    end else begin : g_top
      assign nbr_key  = '0;
      assign nbr_year = '0;
    end

    assign ctl.cmp   = (state == S_CMP);
    assign ctl.live  = CW'(i) < count;
    assign ctl.load  = exec_go && (req_op == krt_pkg::OP_ADD) && !full && (count == CW'(i));
    assign ctl.shift = exec_go && (req_op == krt_pkg::OP_DELETE) && !empty && found &&
                       (IW'(i) >= slot) && (CW'(i + 1) < count);
    assign cell_load[i] = ctl.load;

    krt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .req_key  (req_key),
      .req_year (req_year),
      .nbr_key  (nbr_key),
      .nbr_year (nbr_year),
      .key      (cell_key[i]),
      .year     (cell_year[i]),
      .hit      (cell_hit[i])
    );
  end

  // pad the match row to whole groups
  always_comb begin
    hit_pad  = '0;
    year_pad = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_pad[i]  = cell_hit[i];
      year_pad[i] = cell_year[i];
    end
  end

  // first match within each group
  for (genvar g = 0; g < NG; g++) begin : g_grp
    logic [LW-1:0] loc_idx;
    logic [YW-1:0] loc_year;

    krt_first_pick #(.N(GS), .DW(YW)) u_pick (
      .clk  (clk),
      .rst  (rst),
      .en   (state == S_PICKA),
      .hit  (hit_pad[g*GS +: GS]),
      .data (year_pad[g*GS +: GS]),
      .any  (grp_any[g]),
      .idx  (loc_idx),
      .dout (loc_year)
    );

    assign grp_data[g] = {loc_idx, loc_year};
  end

  // first match across groups
  krt_first_pick #(.N(NG), .DW(LW + YW)) u_pick_top (
    .clk  (clk),
    .rst  (rst),
    .en   (state == S_PICKB),
    .hit  (grp_any),
    .data (grp_data),
    .any  (found),
    .idx  (grp_sel),
    .dout (pick_data)
  );

  assign slot      = IW'({grp_sel, pick_data[LW+YW-1:YW]});
  assign slot_year = pick_data[YW-1:0];

  // execute
  always_comb begin
    res_status = krt_pkg::ST_OK;
    res_pos    = '0;
    res_year   = '0;
    count_next = count;
    case (req_op)
      krt_pkg::OP_ADD: begin
        if (full) begin
          res_status = krt_pkg::ST_FULL;
        end else begin
          count_next = count + CW'(1);
          res_pos    = count + CW'(1);
        end
      end
      krt_pkg::OP_SEARCH, krt_pkg::OP_DELETE: begin
        if (empty) begin
          res_status = krt_pkg::ST_EMPTY;
        end else if (!found) begin
          res_status = krt_pkg::ST_NOT_FOUND;
        end else begin
          res_pos = CW'(slot) + CW'(1);
          if (req_op == krt_pkg::OP_SEARCH) begin
            res_year = slot_year;
          end else begin
            count_next = count - CW'(1);
          end
        end
      end
      default: res_status = krt_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (exec_go) begin
      count <= count_next;
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exec_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      m_tdata <= {6'd0, 8'(count_next), res_year, 8'(res_pos), res_status};
    end
  end

  // checks
  `KRT_ASSERT_NOW(a_count_range, 1'b1, count <= CW'(CAPACITY), "record count above capacity")
  `KRT_ASSERT_NOW(a_single_load, 1'b1, $onehot0(cell_load), "more than one cell loaded")
  `KRT_ASSERT_NOW(a_beat_source, $rose(m_tvalid), $past(state) == S_EXEC, "result beat without execute")
  `KRT_ASSERT_NEXT(a_count_step, 1'b1, (count == $past(count)) || (count == $past(count) + CW'(1)) || (count == $past(count) - CW'(1)), "record count jumped")

endmodule
